FILE: sv/tlv_entity_payload_validator_defines.svh
// Assertion macros used by the top-level validator to check behavior.
`ifndef TLV_ENTITY_PAYLOAD_VALIDATOR_DEFINES_SVH
`define TLV_ENTITY_PAYLOAD_VALIDATOR_DEFINES_SVH

// Checks that an implication holds at every edge outside reset.
`define TLV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlv check failed");

// Checks that a condition holds in the cycle after another.
`define TLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlv check failed");

`endif

FILE: sv/tlv_pkg.sv
package tlv_pkg;

    localparam int MaxRecords   = 16;
    localparam int RelayLimit   = 10;
    localparam int PayloadBytes = 1024;
    localparam logic [31:0] KIND_ABSENT = 32'hFFFF_FFFF;

    localparam logic [2:0] ET_NOTE    = 3'd0;
    localparam logic [2:0] ET_NPUB    = 3'd1;
    localparam logic [2:0] ET_NPROF   = 3'd2;
    localparam logic [2:0] ET_NEVENT  = 3'd3;
    localparam logic [2:0] ET_NRELAY  = 3'd4;
    localparam logic [2:0] ET_NADDR   = 3'd5;

    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_FIXED    = 4'd1;
    localparam logic [3:0] ERR_RECORDS  = 4'd2;
    localparam logic [3:0] ERR_OVERRUN  = 4'd3;
    localparam logic [3:0] ERR_TAG      = 4'd4;
    localparam logic [3:0] ERR_FLEN     = 4'd5;
    localparam logic [3:0] ERR_DUP      = 4'd6;
    localparam logic [3:0] ERR_RELAYS   = 4'd7;
    localparam logic [3:0] ERR_MISSING  = 4'd8;
    localparam logic [3:0] ERR_NRELAY   = 4'd9;
    localparam logic [3:0] ERR_TOO_LONG = 4'd10;

    localparam int QDepth = 4;

    typedef struct packed {
        logic [2:0] entity_type;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        result_is_verdict;
        logic [2:0]  record_role;
        logic [9:0]  record_offset;
        logic [7:0]  record_length;
        logic        payload_valid;
        logic [3:0]  error_code;
        logic [31:0] kind_value;
        logic [3:0]  relay_total;
        logic        run_end;
    } out_item_t;

    // One classified byte: up to two results it caused.
    typedef struct packed {
        logic      has_a;
        out_item_t res_a;
        logic      has_b;
        out_item_t res_b;
    } work_t;

    function automatic logic [1:0] err_rank(input logic [3:0] e);
        if (e == ERR_NONE) return 2'd0;
        if (e == ERR_TOO_LONG) return 2'd3;
        if (e == ERR_RECORDS || e == ERR_OVERRUN) return 2'd2;
        return 2'd1;
    endfunction

    function automatic logic [2:0] role_of(input logic [2:0] et, input logic [7:0] tag);
        if (tag == 8'd1) return 3'd2;
        if (tag == 8'd2) return 3'd1;
        if (tag == 8'd3) return 3'd4;
        if (et == ET_NPROF) return 3'd1;
        if (et == ET_NEVENT) return 3'd0;
        if (et == ET_NRELAY) return 3'd2;
        return 3'd3;
    endfunction

endpackage

FILE: sv/tlv_front.sv
module tlv_front
    import tlv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output work_t    work
);

    logic [2:0]  ent_reg, ent_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  rem_reg, rem_next;
    logic [9:0]  vstart_reg, vstart_next;
    logic [7:0]  clen_reg, clen_next;
    logic [10:0] bcnt_reg, bcnt_next;
    logic [4:0]  rcnt_reg, rcnt_next;
    logic [2:0]  seen_reg, seen_next;
    logic [3:0]  relay_reg, relay_next;
    logic [31:0] kind_reg, kind_next;
    logic [3:0]  err_reg, err_next;

    always_comb
    begin
        logic        done;
        logic [2:0]  et;
        logic [2:0]  role;
        logic [7:0]  b;
        logic [1:0]  pos;
        out_item_t   r;

        ent_next = ent_reg; phase_next = phase_reg; tag_next = tag_reg;
        rem_next = rem_reg; vstart_next = vstart_reg; clen_next = clen_reg;
        bcnt_next = bcnt_reg; rcnt_next = rcnt_reg; seen_next = seen_reg;
        relay_next = relay_reg; kind_next = kind_reg; err_next = err_reg;
        work = '0;
        done = 1'b0;
        b = item.data_byte;
        pos = '0;
        role = '0;
        r = '0;

        if (item.first_byte)
        begin
            phase_next = PH_TAG; tag_next = '0; rem_next = '0; vstart_next = '0;
            clen_next = '0; bcnt_next = '0; rcnt_next = '0; seen_next = '0;
            relay_next = '0; kind_next = KIND_ABSENT; err_next = ERR_NONE;
            ent_next = item.entity_type;
        end
        et = ent_next;

        if (bcnt_next != 11'd2047) bcnt_next = bcnt_next + 11'd1;
        if (bcnt_next > 11'(PayloadBytes) && err_rank(ERR_TOO_LONG) > err_rank(err_next))
            err_next = ERR_TOO_LONG;

        if (et >= ET_NPROF && et <= ET_NADDR && err_rank(err_next) < 2'd2)
        begin
            unique case (phase_next)
                PH_TAG:
                begin
                    if (!item.last_byte)
                    begin
                        if (rcnt_next >= 5'(MaxRecords))
                            err_next = ERR_RECORDS;
                        else
                        begin
                            tag_next = b;
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    clen_next = b;
                    rem_next = b;
                    vstart_next = bcnt_next[9:0];
                    rcnt_next = rcnt_next + 5'd1;
                    if (err_next == ERR_NONE)
                    begin
                        if (et == ET_NRELAY)
                        begin
                            if (rcnt_next != 5'd1 || tag_next != 8'd0) err_next = ERR_NRELAY;
                            else relay_next = relay_next + 4'd1;
                        end
                        else if (tag_next == 8'd1)
                        begin
                            if (relay_next >= 4'(RelayLimit)) err_next = ERR_RELAYS;
                            else relay_next = relay_next + 4'd1;
                        end
                        else if ((tag_next == 8'd2 && (et == ET_NEVENT || et == ET_NADDR)) ||
                                 (tag_next == 8'd0 && (et == ET_NPROF || et == ET_NEVENT)))
                        begin
                            pos = (tag_next == 8'd0 && et == ET_NEVENT) ? 2'd0 : 2'd1;
                            if (b != 8'd32) err_next = ERR_FLEN;
                            else if (seen_next[pos]) err_next = ERR_DUP;
                            else seen_next[pos] = 1'b1;
                        end
                        else if (et == ET_NADDR && tag_next == 8'd0)
                            seen_next[2] = 1'b1;
                        else if (et == ET_NADDR && tag_next == 8'd3)
                        begin
                            if (b != 8'd4) err_next = ERR_FLEN;
                            else if (kind_next != KIND_ABSENT) err_next = ERR_DUP;
                        end
                        else
                            err_next = ERR_TAG;
                    end
                    if (b == 8'd0)
                    begin
                        done = 1'b1;
                        phase_next = PH_TAG;
                    end
                    else
                        phase_next = PH_VAL;
                end
                default:
                begin
                    if (err_next == ERR_NONE && et == ET_NADDR && tag_next == 8'd3)
                    begin
                        pos = 2'(clen_next - rem_next);
                        unique case (pos)
                            2'd0: kind_next[7:0] = b;
                            2'd1: kind_next[15:8] = b;
                            2'd2: kind_next[23:16] = b;
                            default: kind_next[31:24] = b;
                        endcase
                    end
                    rem_next = rem_next - 8'd1;
                    if (rem_next == 8'd0)
                    begin
                        done = 1'b1;
                        phase_next = PH_TAG;
                    end
                end
            endcase
            if (done && err_next == ERR_NONE)
            begin
                role = role_of(et, tag_next);
                r = '0;
                r.record_role = role;
                r.record_offset = vstart_next;
                r.record_length = clen_next;
                r.kind_value = (role == 3'd4) ? kind_next : 32'd0;
                r.relay_total = relay_next;
                r.run_end = !item.last_byte;
                work.has_a = 1'b1;
                work.res_a = r;
            end
            if (item.last_byte && err_rank(err_next) < 2'd2 && phase_next == PH_VAL)
                err_next = ERR_OVERRUN;
        end

        if (item.last_byte)
        begin
            if (err_next == ERR_NONE)
            begin
                if (et <= ET_NPUB)
                begin
                    if (bcnt_next != 11'd32) err_next = ERR_FIXED;
                    else
                    begin
                        r = '0;
                        r.record_role = et;
                        r.record_length = 8'd32;
                        r.relay_total = relay_next;
                        work.has_a = 1'b1;
                        work.res_a = r;
                    end
                end
                else if (et == ET_NPROF)
                begin
                    if (!seen_next[1]) err_next = ERR_MISSING;
                end
                else if (et == ET_NEVENT)
                begin
                    if (!seen_next[0]) err_next = ERR_MISSING;
                end
                else if (et == ET_NRELAY)
                begin
                    if (rcnt_next != 5'd1) err_next = ERR_NRELAY;
                end
                else if (et == ET_NADDR)
                begin
                    if (!seen_next[2] || !seen_next[1] || kind_next == KIND_ABSENT)
                        err_next = ERR_MISSING;
                end
                else
                    err_next = ERR_TAG;
            end
            r = '0;
            r.result_is_verdict = 1'b1;
            r.payload_valid = (err_next == ERR_NONE);
            r.error_code = err_next;
            r.kind_value = kind_next;
            r.relay_total = relay_next;
            r.run_end = 1'b1;
            work.has_b = 1'b1;
            work.res_b = r;
            phase_next = PH_TAG; tag_next = '0; rem_next = '0; vstart_next = '0;
            clen_next = '0; bcnt_next = '0; rcnt_next = '0; seen_next = '0;
            relay_next = '0; kind_next = KIND_ABSENT; err_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0; phase_reg <= PH_TAG; tag_reg <= '0; rem_reg <= '0;
            vstart_reg <= '0; clen_reg <= '0; bcnt_reg <= '0; rcnt_reg <= '0;
            seen_reg <= '0; relay_reg <= '0; kind_reg <= KIND_ABSENT; err_reg <= ERR_NONE;
        end
        else if (take)
        begin
            ent_reg <= ent_next; phase_reg <= phase_next; tag_reg <= tag_next;
            rem_reg <= rem_next; vstart_reg <= vstart_next; clen_reg <= clen_next;
            bcnt_reg <= bcnt_next; rcnt_reg <= rcnt_next; seen_reg <= seen_next;
            relay_reg <= relay_next; kind_reg <= kind_next; err_reg <= err_next;
        end
    end

endmodule

FILE: sv/tlv_queue.sv
module tlv_queue
    import tlv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t head,
    output logic  not_empty,
    output logic  not_full
);

    localparam int PtrW = $clog2(QDepth);

    work_t         mem_reg [QDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0]   cnt_reg;

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != (PtrW+1)'(QDepth));

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

endmodule

FILE: sv/tlv_back.sv
module tlv_back
    import tlv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      have,
    input  work_t     work,
    output logic      pop,
    output logic      out_valid,
    output out_item_t out_item,
    input  logic      out_ready
);

    logic      a_done_reg, a_done_next;
    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;
    logic      load;
    logic      use_a;

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign load = !valid_reg || out_ready;
    assign use_a = work.has_a && !a_done_reg;

    always_comb
    begin
        pop = 1'b0;
        a_done_next = a_done_reg;
        valid_next = valid_reg && !out_ready;
        item_next = item_reg;
        if (load && have)
        begin
            if (use_a)
            begin
                valid_next = 1'b1;
                item_next = work.res_a;
                if (work.has_b) a_done_next = 1'b1;
                else pop = 1'b1;
            end
            else
            begin
                pop = 1'b1;
                a_done_next = 1'b0;
                valid_next = work.has_b;
                item_next = work.res_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_done_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            a_done_reg <= a_done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

FILE: sv/tlv_entity_payload_validator.sv
// Typed-entity payload validator.
// Input channel in_valid/in_ready/in_data carries one payload byte per
// transaction with first and last markers; the entity type is taken on the first byte.
// Output channel out_valid/out_ready/out_data carries record descriptions and,
// after the last byte, a verdict with an error code; run_end marks the last
// result of each byte.
// The front end classifies one byte per cycle unless the queue is full and writes
// its results into a four-entry queue; the back end sends one result per cycle from
// that queue while out_ready is high. The results of a byte are written into the queue
// when the byte is accepted and reach the receiver through the output register.
// Throughput is one byte per cycle while each byte causes at most one result and
// out_ready stays high; a byte causing two results sends them one after the other.
// Reset clears all parse state, the queue pointers and the output valid flag.
// When the receiver stalls, the queue fills and in_ready drops once it is full.
`include "tlv_entity_payload_validator_defines.svh"
module tlv_entity_payload_validator
    import tlv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    work_t work, head;
    logic  take, pop, not_empty, not_full, push;

    assign in_ready = not_full;
    assign take = in_valid && in_ready;
    assign push = take && (work.has_a || work.has_b);

    tlv_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(in_data), .work(work)
    );

    tlv_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(work), .pop(pop),
        .head(head), .not_empty(not_empty), .not_full(not_full)
    );

    tlv_back u_back (
        .clk(clk), .rst_n(rst_n), .have(not_empty), .work(head), .pop(pop),
        .out_valid(out_valid), .out_item(out_data), .out_ready(out_ready)
    );

    `TLV_ASSERT_IMPL(a_no_pop_empty, pop, not_empty)
    `TLV_ASSERT_IMPL(a_verdict_ends, out_valid && out_data.result_is_verdict, out_data.run_end)
    `TLV_ASSERT_NEXT(a_pop_fills, pop, out_valid)
    `TLV_ASSERT_IMPL(a_ok_no_err,
        out_valid && out_data.payload_valid, out_data.error_code == ERR_NONE)

endmodule
